/* design/mqsm_pkg.sv */
`timescale 1ns / 1ps

package mqsm_pkg;

    // command codes
    localparam logic [2:0] FN_PUSH    = 3'd0;
    localparam logic [2:0] FN_MOVE    = 3'd1;
    localparam logic [2:0] FN_DEFER   = 3'd2;
    localparam logic [2:0] FN_RESTORE = 3'd3;
    localparam logic [2:0] FN_DISCARD = 3'd4;
    localparam logic [2:0] FN_SHIP    = 3'd5;

    // report kinds
    localparam logic [1:0] KIND_SHIP    = 2'd0;
    localparam logic [1:0] KIND_DISCARD = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    // classified command from front to back
    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  line;
        logic [31:0] id;
        logic        range_err;
    } t_cmd;

    // one report item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [1:0]  err;
    } t_rpt;

endpackage

/* design/mqsm_ram.sv */
`timescale 1ns / 1ps

module mqsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/mqsm_front.sv */
`timescale 1ns / 1ps

module mqsm_front #(
    parameter int MAX_LINES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [2:0]         i_func,
    input  logic [2:0]         i_line,
    input  logic [31:0]        i_item_id,
    input  logic [3:0]         i_active_lines,
    output logic               o_cmd_valid,
    output mqsm_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);

    logic [1:0]     r_cnt;
    logic           r_wp;
    logic           r_rp;
    mqsm_pkg::t_cmd r_slot [2];
    logic [7:0]     limit;
    logic [2:0]     line_eff;
    logic           accept;
    logic           keep;
    mqsm_pkg::t_cmd cmd_in;

    // classify: push always targets line 0, check the line limit
    always_comb begin
        limit = ({4'b0, i_active_lines} < 8'(MAX_LINES)) ? {4'b0, i_active_lines}
                                                          : 8'(MAX_LINES);
        line_eff = (i_func == mqsm_pkg::FN_PUSH) ? 3'd0 : i_line;
        cmd_in.op        = i_func;
        cmd_in.line      = line_eff;
        cmd_in.id        = i_item_id;
        cmd_in.range_err = ({5'b0, line_eff} >= limit);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign accept  = i_push && !o_full;
    // unknown commands are taken and dropped
    assign keep    = accept && (i_func <= mqsm_pkg::FN_SHIP);

    // two-slot command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (keep) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, keep} - {1'b0, i_cmd_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_slot[r_wp] <= cmd_in;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rp];

endmodule

/* design/mqsm_rpt_q.sv */
`timescale 1ns / 1ps

module mqsm_rpt_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  mqsm_pkg::t_rpt i_rpt,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output mqsm_pkg::t_rpt o_rpt
);

    logic [1:0]     r_cnt;
    logic           r_wp;
    logic           r_rp;
    mqsm_pkg::t_rpt r_slot [2];
    logic           take;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign take    = i_pop && !o_empty;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wp <= !r_wp;
            end
            if (take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wp] <= i_rpt;
        end
    end

    assign o_rpt = r_slot[r_rp];

endmodule

/* design/mqsm_back.sv */
`timescale 1ns / 1ps

module mqsm_back #(
    parameter int MAX_LINES  = 8,
    parameter int POOL_CELLS = 1024,
    parameter int ID_BITS    = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  mqsm_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_rpt_full,
    output logic           o_rpt_wr,
    output mqsm_pkg::t_rpt o_rpt
);

    localparam int PW = $clog2(POOL_CELLS);
    localparam int CW = $clog2(POOL_CELLS + 1);
    localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    localparam logic ST_LOOK = 1'b0;
    localparam logic ST_DO   = 1'b1;

    logic               r_state;
    logic [CW-1:0]      r_fresh, n_fresh;
    logic [PW-1:0]      r_free_top, n_free_top;
    logic [CW-1:0]      r_free_len, n_free_len;
    logic [PW-1:0]      r_qf [MAX_LINES];
    logic [PW-1:0]      r_qb [MAX_LINES];
    logic [CW-1:0]      r_ql [MAX_LINES];
    logic [PW-1:0]      r_st [MAX_LINES];
    logic [CW-1:0]      r_sl [MAX_LINES];
    logic [PW-1:0]      n_qf [MAX_LINES];
    logic [PW-1:0]      n_qb [MAX_LINES];
    logic [CW-1:0]      n_ql [MAX_LINES];
    logic [PW-1:0]      n_st [MAX_LINES];
    logic [CW-1:0]      n_sl [MAX_LINES];

    // latched command
    logic [2:0]         r_op;
    logic [LW-1:0]      r_bi;
    logic [PW-1:0]      r_cell;
    logic [1:0]         r_err;
    logic [ID_BITS-1:0] r_id;
    logic               r_from_free;

    logic [7:0]         line_ext;
    logic [LW-1:0]      bi;
    logic [1:0]         l_err;
    logic [PW-1:0]      l_src;
    logic               l_from_free;
    logic [63:0]        id_ext;
    logic [63:0]        item_ext;

    logic [PW-1:0]      link_rd;
    logic [ID_BITS-1:0] item_rd;
    logic               lwr_en;
    logic [PW-1:0]      lwr_addr;
    logic [PW-1:0]      lwr_data;
    logic               iwr_en;

    logic               needs_out;
    logic               fire;
    logic               apply;
    logic               q_pop_en, s_pop_en, app_en, s_push_en, free_en;
    logic [LW-1:0]      pop_line, app_line;

    // look up the source cell of the head command
    always_comb begin
        line_ext    = {5'b0, i_cmd.line};
        bi          = line_ext[LW-1:0];
        l_err       = mqsm_pkg::ERR_NONE;
        l_src       = r_qf[bi];
        l_from_free = 1'b0;
        if (i_cmd.range_err) begin
            l_err = mqsm_pkg::ERR_RANGE;
        end else begin
            unique case (i_cmd.op)
                mqsm_pkg::FN_PUSH: begin
                    if (r_free_len != '0) begin
                        l_src       = r_free_top;
                        l_from_free = 1'b1;
                    end else if (r_fresh < CW'(POOL_CELLS)) begin
                        l_src = r_fresh[PW-1:0];
                    end else begin
                        l_err = mqsm_pkg::ERR_FULL;
                    end
                end
                mqsm_pkg::FN_MOVE: begin
                    l_src = r_qf[0];
                    if (r_ql[0] == '0) begin
                        l_err = mqsm_pkg::ERR_EMPTY;
                    end
                end
                mqsm_pkg::FN_DEFER, mqsm_pkg::FN_SHIP: begin
                    l_src = r_qf[bi];
                    if (r_ql[bi] == '0) begin
                        l_err = mqsm_pkg::ERR_EMPTY;
                    end
                end
                mqsm_pkg::FN_RESTORE, mqsm_pkg::FN_DISCARD: begin
                    l_src = r_st[bi];
                    if (r_sl[bi] == '0) begin
                        l_err = mqsm_pkg::ERR_EMPTY;
                    end
                end
                default: begin
                    l_err = mqsm_pkg::ERR_NONE;
                end
            endcase
        end
    end

    assign o_cmd_pop = (r_state == ST_LOOK) && i_cmd_valid;
    assign id_ext    = {32'b0, i_cmd.id};

    assign needs_out = (r_err != mqsm_pkg::ERR_NONE) || (r_op == mqsm_pkg::FN_DISCARD)
                       || (r_op == mqsm_pkg::FN_SHIP);
    assign fire      = (r_state == ST_DO) && (!needs_out || !i_rpt_full);
    assign apply     = fire && (r_err == mqsm_pkg::ERR_NONE);

    // relink: pop from the source list, then append or push onto the target
    always_comb begin
        n_fresh    = r_fresh;
        n_free_top = r_free_top;
        n_free_len = r_free_len;
        n_qf = r_qf;
        n_qb = r_qb;
        n_ql = r_ql;
        n_st = r_st;
        n_sl = r_sl;
        lwr_en   = 1'b0;
        lwr_addr = r_cell;
        lwr_data = r_free_top;
        iwr_en   = 1'b0;

        q_pop_en  = (r_op == mqsm_pkg::FN_MOVE) || (r_op == mqsm_pkg::FN_DEFER)
                    || (r_op == mqsm_pkg::FN_SHIP);
        s_pop_en  = (r_op == mqsm_pkg::FN_RESTORE) || (r_op == mqsm_pkg::FN_DISCARD);
        app_en    = (r_op == mqsm_pkg::FN_PUSH) || (r_op == mqsm_pkg::FN_MOVE)
                    || (r_op == mqsm_pkg::FN_RESTORE);
        s_push_en = (r_op == mqsm_pkg::FN_DEFER);
        free_en   = (r_op == mqsm_pkg::FN_DISCARD) || (r_op == mqsm_pkg::FN_SHIP);
        pop_line  = (r_op == mqsm_pkg::FN_MOVE) ? '0 : r_bi;
        app_line  = (r_op == mqsm_pkg::FN_PUSH) ? '0 : r_bi;

        if (apply) begin
            // allocate the cell for a new item
            if (r_op == mqsm_pkg::FN_PUSH) begin
                iwr_en = 1'b1;
                if (r_from_free) begin
                    n_free_top = link_rd;
                    n_free_len = r_free_len - CW'(1);
                end else begin
                    n_fresh = r_fresh + CW'(1);
                end
            end
            if (q_pop_en) begin
                n_qf[pop_line] = link_rd;
                n_ql[pop_line] = n_ql[pop_line] - CW'(1);
            end
            if (s_pop_en) begin
                n_st[r_bi] = link_rd;
                n_sl[r_bi] = n_sl[r_bi] - CW'(1);
            end
            if (app_en) begin
                if (n_ql[app_line] == '0) begin
                    n_qf[app_line] = r_cell;
                end else begin
                    lwr_en   = 1'b1;
                    lwr_addr = n_qb[app_line];
                    lwr_data = r_cell;
                end
                n_qb[app_line] = r_cell;
                n_ql[app_line] = n_ql[app_line] + CW'(1);
            end
            if (s_push_en) begin
                lwr_en     = 1'b1;
                lwr_addr   = r_cell;
                lwr_data   = n_st[r_bi];
                n_st[r_bi] = r_cell;
                n_sl[r_bi] = n_sl[r_bi] + CW'(1);
            end
            if (free_en) begin
                lwr_en     = 1'b1;
                lwr_addr   = r_cell;
                lwr_data   = r_free_top;
                n_free_top = r_cell;
                n_free_len = r_free_len + CW'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOOK;
            r_fresh    <= '0;
            r_free_top <= '0;
            r_free_len <= '0;
            for (int i = 0; i < MAX_LINES; i++) begin
                r_qf[i] <= '0;
                r_qb[i] <= '0;
                r_ql[i] <= '0;
                r_st[i] <= '0;
                r_sl[i] <= '0;
            end
        end else begin
            if (o_cmd_pop) begin
                r_state <= ST_DO;
            end else if (fire) begin
                r_state <= ST_LOOK;
            end
            r_fresh    <= n_fresh;
            r_free_top <= n_free_top;
            r_free_len <= n_free_len;
            r_qf <= n_qf;
            r_qb <= n_qb;
            r_ql <= n_ql;
            r_st <= n_st;
            r_sl <= n_sl;
        end
    end

    // hold the command for its update cycle
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_op        <= i_cmd.op;
            r_bi        <= bi;
            r_cell      <= l_src;
            r_err       <= l_err;
            r_id        <= id_ext[ID_BITS-1:0];
            r_from_free <= l_from_free;
        end
    end

    mqsm_ram #(.WIDTH(PW), .DEPTH(POOL_CELLS)) u_link (
        .i_clk     (i_clk),
        .i_wr_en   (lwr_en),
        .i_wr_addr (lwr_addr),
        .i_wr_data (lwr_data),
        .i_rd_en   (o_cmd_pop),
        .i_rd_addr (l_src),
        .o_rd_data (link_rd)
    );

    mqsm_ram #(.WIDTH(ID_BITS), .DEPTH(POOL_CELLS)) u_item (
        .i_clk     (i_clk),
        .i_wr_en   (iwr_en),
        .i_wr_addr (r_cell),
        .i_wr_data (r_id),
        .i_rd_en   (o_cmd_pop),
        .i_rd_addr (l_src),
        .o_rd_data (item_rd)
    );

    // build the report
    assign item_ext = 64'(item_rd);
    assign o_rpt_wr = fire && needs_out;
    always_comb begin
        if (r_err != mqsm_pkg::ERR_NONE) begin
            o_rpt.kind = mqsm_pkg::KIND_REJECT;
            o_rpt.id   = 32'd0;
        end else begin
            o_rpt.kind = (r_op == mqsm_pkg::FN_DISCARD) ? mqsm_pkg::KIND_DISCARD
                                                         : mqsm_pkg::KIND_SHIP;
            o_rpt.id   = item_ext[31:0];
        end
        o_rpt.err = r_err;
    end

endmodule

/* design/multi_queue_stack_manager.sv */
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// command   push / full                i_func, i_line, i_item_id
// report    empty / pop                o_report_kind, o_report_id, o_error_code
// config    i_cfg_valid / o_cfg_ready  i_cfg_data (active_lines)
//
// In the back end, ST_LOOK takes each command and reads the link and item
// memories at the source cell; ST_DO updates list heads and at most one link.
// A two-slot command queue and a two-slot report queue part the sides.
// Synchronous active-low reset empties every list; the pool memories need no
// clearing pass. A full report queue stalls the back end on commands that
// report, and full rises once the two command slots behind it have filled.

module multi_queue_stack_manager #(
    parameter int MAX_LINES  = 8,
    parameter int POOL_CELLS = 1024,
    parameter int ID_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_line,
    input  logic [31:0] i_item_id,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_report_kind,
    output logic [31:0] o_report_id,
    output logic [1:0]  o_error_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    logic [3:0]     r_active_lines;
    logic           cmd_valid;
    logic           cmd_pop;
    mqsm_pkg::t_cmd cmd;
    logic           rpt_full;
    logic           rpt_wr;
    mqsm_pkg::t_rpt rpt_in;
    mqsm_pkg::t_rpt rpt_out;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_lines <= 4'd8;
        end else if (i_cfg_valid) begin
            r_active_lines <= i_cfg_data;
        end
    end

    mqsm_front #(.MAX_LINES(MAX_LINES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_func         (i_func),
        .i_line         (i_line),
        .i_item_id      (i_item_id),
        .i_active_lines (r_active_lines),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    mqsm_back #(
        .MAX_LINES  (MAX_LINES),
        .POOL_CELLS (POOL_CELLS),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_rpt_full  (rpt_full),
        .o_rpt_wr    (rpt_wr),
        .o_rpt       (rpt_in)
    );

    mqsm_rpt_q u_rpt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rpt_wr),
        .i_rpt   (rpt_in),
        .o_full  (rpt_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_rpt   (rpt_out)
    );

    assign o_report_kind = rpt_out.kind;
    assign o_report_id   = rpt_out.id;
    assign o_error_code  = rpt_out.err;

endmodule

/* design/mqsm_checker.sv */
`timescale 1ns / 1ps

module mqsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic [1:0]  o_report_kind,
    input logic [31:0] o_report_id,
    input logic [1:0]  o_error_code
);

    // reset leaves no report waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("report waiting after reset");

    // a reject always carries a reason and no item
    a_reject_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_report_kind == mqsm_pkg::KIND_REJECT)
        |-> (o_error_code != mqsm_pkg::ERR_NONE && o_report_id == 32'd0))
        else $error("reject without reason or with item");

    // ship and discard carry no error
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_report_kind != mqsm_pkg::KIND_REJECT)
        |-> (o_error_code == mqsm_pkg::ERR_NONE))
        else $error("error code on ship or discard");

    // no undefined report kind
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_report_kind != 2'd3))
        else $error("undefined report kind");

endmodule

bind multi_queue_stack_manager mqsm_checker u_mqsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .o_report_kind (o_report_kind),
    .o_report_id   (o_report_id),
    .o_error_code  (o_error_code)
);
